// File: hdl/bmp24_to_mono_packer_defines.svh
// Assertion macros shared by the packer RTL.
`ifndef BMP24_TO_MONO_PACKER_DEFINES_SVH
`define BMP24_TO_MONO_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmp packer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmp packer: next-cycle check failed");

`endif

// File: hdl/bmp_pkg.sv
// Shared types, sizes and codes for the BMP to mono packer.
package bmp_pkg;

  // Image limits and the counter widths that follow from them
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int BW_W       = $clog2(MAX_WIDTH / 8 + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int IDX_W      = 17;
  localparam int POS_W      = 32;

  // Parse modes
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  // Header byte positions
  localparam logic [POS_W-1:0] POS_DATA_OFFSET = 32'h0A;
  localparam logic [POS_W-1:0] POS_WIDTH       = 32'h12;
  localparam logic [POS_W-1:0] POS_HEIGHT      = 32'h16;
  localparam logic [POS_W-1:0] POS_DEPTH       = 32'h1C;
  localparam logic [POS_W-1:0] POS_CHECK       = 32'h1D;

  localparam logic [15:0]      DEPTH_24        = 16'd24;
  localparam logic [31:0]      MIN_OFFSET      = 32'd30;
  localparam logic [7:0]       THRESHOLD_RESET = 8'd150;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       packed_byte;
    logic [IDX_W-1:0] byte_index;
    logic             final_byte;
    logic             bad_format;
  } out_word_t;

  // Header status toward the mode control and the packer
  typedef struct packed {
    logic             check;
    logic             bad;
    logic             empty;
    logic             reached;
    logic [BW_W-1:0]  bw;
    logic [ROW_W-1:0] height;
  } hdr_stat_t;

  // Packer result toward the output register
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [7:0]       packed_byte;
    logic [IDX_W-1:0] index;
  } pack_res_t;

endpackage

// File: hdl/bmp_hdr.sv
// Header capture, byte position counter and format check.
module bmp_hdr (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              start,
  input  logic              in_header,
  input  logic [7:0]        pixel,
  output bmp_pkg::hdr_stat_t stat
);
  import bmp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [31:0]      data_offset;
  logic [31:0]      image_width;
  logic [31:0]      image_height;
  logic [15:0]      pixel_depth;
  logic [15:0]      depth_chk;
  logic [POS_W-1:0] pos_eff;
  logic [1:0]       off_lane;
  logic [1:0]       wid_lane;
  logic [1:0]       hgt_lane;
  logic             dep_lane;

  // Lane of each multi-byte field written by the current byte
  assign off_lane = pos[1:0] - POS_DATA_OFFSET[1:0];
  assign wid_lane = pos[1:0] - POS_WIDTH[1:0];
  assign hgt_lane = pos[1:0] - POS_HEIGHT[1:0];
  assign dep_lane = pos[0] ^ POS_DEPTH[0];

  // Check the header on its last byte, including that byte
  assign pos_eff   = start ? '0 : pos;
  assign depth_chk = {pixel, pixel_depth[7:0]};

  always_comb begin
    stat.check   = in_header && (pos_eff == POS_CHECK);
    stat.bad     = (depth_chk != DEPTH_24)
                || (!image_width[31] && (image_width > 32'(MAX_WIDTH)))
                || (!image_height[31] && (image_height > 32'(MAX_HEIGHT)))
                || data_offset[31] || (data_offset < MIN_OFFSET);
    stat.empty   = image_height[31] || (image_height == '0)
                || image_width[31] || (image_width[31:3] == '0);
    stat.reached = (pos >= data_offset);
    stat.bw      = image_width[BW_W+2:3];
    stat.height  = image_height[ROW_W-1:0];
  end

  // Advance the position and capture header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      data_offset  <= '0;
      image_width  <= '0;
      image_height <= '0;
      pixel_depth  <= '0;
    end else if (fire) begin
      if (start) begin
        pos          <= POS_W'(1);
        data_offset  <= '0;
        image_width  <= '0;
        image_height <= '0;
        pixel_depth  <= '0;
      end else begin
        if (pos != '1) begin
          pos <= pos + POS_W'(1);
        end
        if (in_header) begin
          if (pos >= POS_DATA_OFFSET && pos <= POS_DATA_OFFSET + POS_W'(3)) begin
            data_offset[8*off_lane +: 8] <= pixel;
          end else if (pos >= POS_WIDTH && pos <= POS_WIDTH + POS_W'(3)) begin
            image_width[8*wid_lane +: 8] <= pixel;
          end else if (pos >= POS_HEIGHT && pos <= POS_HEIGHT + POS_W'(3)) begin
            image_height[8*hgt_lane +: 8] <= pixel;
          end else if (pos >= POS_DEPTH && pos <= POS_DEPTH + POS_W'(1)) begin
            pixel_depth[8*dep_lane +: 8] <= pixel;
          end
        end
      end
    end
  end

endmodule

// File: hdl/bmp_pack.sv
// Pixel thresholding, bit packing and mirrored destination index.
module bmp_pack (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      start,
  input  logic                      enable,
  input  logic [7:0]                pixel,
  input  logic [7:0]                thresh,
  input  logic [bmp_pkg::BW_W-1:0]  bw,
  input  logic [bmp_pkg::ROW_W-1:0] height,
  output bmp_pkg::pack_res_t        res
);
  import bmp_pkg::*;

  logic [1:0]       phase;
  logic [2:0]       bit_cnt;
  logic [7:0]       accum;
  logic [BW_W-1:0]  col;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] row_base;

  logic             hit;
  logic [7:0]       accum_set;
  logic [BW_W-1:0]  col_inc;
  logic [ROW_W-1:0] row_inc;
  logic             row_end;

  // Threshold the blue byte and merge it into the word being built
  assign hit       = (phase == 2'd0) && (pixel > thresh);
  assign accum_set = accum | (8'(hit) << bit_cnt);
  assign col_inc   = col + BW_W'(1);
  assign row_inc   = row + ROW_W'(1);
  assign row_end   = (col_inc >= bw);

  always_comb begin
    res.emit        = enable && (phase == 2'd2) && (bit_cnt == 3'd7);
    res.last        = row_end && (row_inc >= height);
    res.packed_byte = accum_set;
    res.index       = row_base + IDX_W'(bw) - IDX_W'(1) - IDX_W'(col);
  end

  // Step the color phase, bit and column/row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      bit_cnt  <= '0;
      accum    <= '0;
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (fire) begin
      if (start) begin
        phase    <= '0;
        bit_cnt  <= '0;
        accum    <= '0;
        col      <= '0;
        row      <= '0;
        row_base <= '0;
      end else if (enable) begin
        if (phase < 2'd2) begin
          phase <= phase + 2'd1;
          accum <= accum_set;
        end else begin
          phase   <= '0;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt != 3'd7) begin
            accum <= accum_set;
          end else begin
            accum <= '0;
            if (row_end) begin
              col      <= '0;
              row      <= row_inc;
              row_base <= row_base + IDX_W'(bw);
            end else begin
              col <= col_inc;
            end
          end
        end
      end
    end
  end

endmodule

// File: hdl/bmp24_to_mono_packer.sv
// Top level of the 24 bpp BMP to 1 bpp packer: handshakes, parse mode, register port.
// The block takes one file byte per clock cycle while the result side takes its words;
// each byte passes through the input register, and each packed word through the result
// register. The path between the two registers is one byte compare, the 32-bit
// position compare for the skip to pixel data, and the 17-bit destination index add.
// Header fields are read little-endian; a rejected header gives a single word with
// bad_format set and the rest of that file is dropped, as are bytes after the last
// packed word. A word with file_start set restarts parsing at once. There is no
// clearing pass after reset. blue_threshold answers at every register address and
// resets to 150.
`include "bmp24_to_mono_packer_defines.svh"

module bmp24_to_mono_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               file_valid,
  output logic               file_ready,
  input  bmp_pkg::in_word_t  file_word,
  output logic               pack_valid,
  input  logic               pack_ready,
  output bmp_pkg::out_word_t pack_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bmp_pkg::*;

  logic       s1_valid;
  in_word_t   s1_word;
  logic       s1_fire;
  logic [7:0] blue_threshold;
  logic [1:0] mode;
  logic [1:0] mode_eff;
  logic [1:0] mode_next;
  logic       in_header;
  logic       data_en;
  logic       bad_emit;
  hdr_stat_t  hs;
  pack_res_t  pk;

  // Register port: one register, written in the access phase
  assign pready = 1'b1;
  assign prdata = {24'd0, blue_threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0 || paddr != 2'd0)) begin
      blue_threshold <= pwdata[7:0];
    end
  end

  // Input register: advance when the result register can take a word
  assign s1_fire    = s1_valid && (!pack_valid || pack_ready);
  assign file_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (file_valid && file_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (file_valid && file_ready) begin
      s1_word <= file_word;
    end
  end

  // Parse mode control
  assign mode_eff  = s1_word.file_start ? MODE_HEADER : mode;
  assign in_header = (mode_eff == MODE_HEADER);

  always_comb begin
    mode_next = mode_eff;
    data_en   = 1'b0;
    bad_emit  = 1'b0;
    unique case (mode_eff)
      MODE_HEADER: begin
        if (hs.check) begin
          if (hs.bad) begin
            mode_next = MODE_DONE;
            bad_emit  = 1'b1;
          end else if (hs.empty) begin
            mode_next = MODE_DONE;
          end else begin
            mode_next = MODE_SKIP;
          end
        end
      end
      MODE_SKIP: begin
        if (hs.reached) begin
          mode_next = MODE_DATA;
          data_en   = 1'b1;
        end
      end
      MODE_DATA: begin
        data_en = 1'b1;
      end
      default: begin
        mode_next = MODE_DONE;
      end
    endcase
    if (pk.emit && pk.last) begin
      mode_next = MODE_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HEADER;
    end else if (s1_fire) begin
      mode <= mode_next;
    end
  end

  bmp_hdr u_hdr (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .start     (s1_word.file_start),
    .in_header (in_header),
    .pixel     (s1_word.file_byte),
    .stat      (hs)
  );

  bmp_pack u_pack (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .start  (s1_word.file_start),
    .enable (data_en),
    .pixel  (s1_word.file_byte),
    .thresh (blue_threshold),
    .bw     (hs.bw),
    .height (hs.height),
    .res    (pk)
  );

  // Result register: load a word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_valid <= 1'b0;
    end else if (s1_fire && (pk.emit || bad_emit)) begin
      pack_valid <= 1'b1;
    end else if (pack_ready) begin
      pack_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && bad_emit) begin
      pack_word.packed_byte <= '0;
      pack_word.byte_index  <= '0;
      pack_word.final_byte  <= 1'b0;
      pack_word.bad_format  <= 1'b1;
    end else if (s1_fire && pk.emit) begin
      pack_word.packed_byte <= pk.packed_byte;
      pack_word.byte_index  <= pk.index;
      pack_word.final_byte  <= pk.last;
      pack_word.bad_format  <= 1'b0;
    end
  end

  `BMP_ASSERT_SAME(a_bad_word_clear, clk, rst, pack_valid && pack_word.bad_format, pack_word.packed_byte == '0 && pack_word.byte_index == '0 && !pack_word.final_byte)
  `BMP_ASSERT_NEXT(a_final_ends_image, clk, rst, s1_fire && pk.emit && pk.last, mode == MODE_DONE)
  `BMP_ASSERT_SAME(a_data_has_width, clk, rst, mode == MODE_DATA, hs.bw != '0)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 24 bpp BMP to 1 bpp packer: directed and random files.
module testbench;
  import bmp_pkg::*;

  localparam logic [1:0]  ADDR_BLUE_THRESHOLD = 2'd0;
  localparam int unsigned CYCLE_LIMIT         = 1000000;
  localparam int unsigned RANDOM_BYTES        = 200;
  localparam int unsigned RANDOM_WORDS        = 16;
  localparam int unsigned SETTLE_CYCLES       = 6;
  localparam int unsigned IDLE_MAX            = 19;
  localparam int unsigned LONG_HOLD           = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        file_valid;
  logic        file_ready;
  in_word_t    file_word;
  logic        pack_valid;
  logic        pack_ready;
  out_word_t   pack_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bmp24_to_mono_packer dut (.*);

  // Packer state as predicted from the accepted file bytes
  logic [7:0]  model_thresh;
  logic [1:0]  model_mode;
  logic [31:0] model_pos;
  logic [31:0] model_offset;
  logic [31:0] model_width;
  logic [31:0] model_height;
  logic [15:0] model_depth;
  int unsigned model_phase;
  int unsigned model_bits;
  logic [7:0]  model_accum;
  int unsigned model_col;
  logic [31:0] model_row;
  logic [31:0] model_base;

  out_word_t   packed_queue[$];

  int unsigned bytes_sent    = 0;
  int unsigned words_seen    = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned src_idle_max  = IDLE_MAX;
  int unsigned sink_idle_max = IDLE_MAX;
  int unsigned sink_hold     = 0;

  always #1 clk = ~clk;

  // Drop all parse progress, as on reset or a file start
  function automatic void restart_parse();
    model_mode   = MODE_HEADER;
    model_pos    = '0;
    model_offset = '0;
    model_width  = '0;
    model_height = '0;
    model_depth  = '0;
    model_phase  = 0;
    model_bits   = 0;
    model_accum  = '0;
    model_col    = 0;
    model_row    = '0;
    model_base   = '0;
  endfunction

  function automatic logic [31:0] row_bytes();
    return model_width[31] ? 32'd0 : model_width / 8;
  endfunction

  // Advance the predicted packer by one file byte; queue the word it yields
  function automatic void take_file_byte(input in_word_t w);
    logic [31:0] pos;
    logic [31:0] bw;
    logic [7:0]  b;
    logic        rejected;
    out_word_t   r;
    b = w.file_byte;
    r = '0;
    if (w.file_start) restart_parse();
    pos = model_pos;
    if (model_pos != '1) model_pos++;

    if (model_mode == MODE_HEADER) begin
      if (pos >= POS_DATA_OFFSET && pos < POS_DATA_OFFSET + 4)
        model_offset |= 32'(b) << (8 * (pos - POS_DATA_OFFSET));
      else if (pos >= POS_WIDTH && pos < POS_WIDTH + 4)
        model_width |= 32'(b) << (8 * (pos - POS_WIDTH));
      else if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 4)
        model_height |= 32'(b) << (8 * (pos - POS_HEIGHT));
      else if (pos >= POS_DEPTH && pos < POS_DEPTH + 2)
        model_depth |= 16'(b) << (8 * (pos - POS_DEPTH));
      if (pos == POS_CHECK) begin
        rejected = model_depth != DEPTH_24
          || (!model_width[31] && model_width > 32'(MAX_WIDTH))
          || (!model_height[31] && model_height > 32'(MAX_HEIGHT))
          || model_offset[31] || model_offset < MIN_OFFSET;
        if (rejected) begin
          model_mode = MODE_DONE;
          r.bad_format = 1'b1;
          packed_queue.push_back(r);
        end else if (model_height[31] || model_height == 0 || row_bytes() == 0) begin
          model_mode = MODE_DONE;
        end else begin
          model_mode = MODE_SKIP;
        end
      end
      return;
    end
    if (model_mode == MODE_SKIP) begin
      if (pos < model_offset) return;
      model_mode = MODE_DATA;
    end
    if (model_mode != MODE_DATA) return;

    // Threshold the blue byte, pack eight pixels per word
    bw = row_bytes();
    if (model_phase == 0 && b > model_thresh) model_accum[model_bits] = 1'b1;
    if (model_phase < 2) begin
      model_phase++;
      return;
    end
    model_phase = 0;
    model_bits++;
    if (model_bits < 8) return;
    model_bits = 0;
    r.packed_byte = model_accum;
    r.byte_index = IDX_W'(model_base + bw - 1 - model_col);
    model_accum = '0;
    model_col++;
    if (model_col >= bw) begin
      model_col = 0;
      model_row++;
      model_base += bw;
      if (model_row >= model_height) begin
        r.final_byte = 1'b1;
        model_mode = MODE_DONE;
      end
    end
    packed_queue.push_back(r);
  endfunction

  // Predict on accepted bytes, check accepted words in order
  always @(posedge clk) begin : scoreboard
    out_word_t want;
    if (!rst) begin
      if (file_valid && file_ready) take_file_byte(file_word);
      if (pack_valid && pack_ready) begin
        words_seen++;
        if (packed_queue.size() == 0) begin
          $error("unexpected word: packed_byte %02h byte_index %0d final_byte %0b bad_format %0b",
                 pack_word.packed_byte, pack_word.byte_index, pack_word.final_byte,
                 pack_word.bad_format);
          error_count++;
        end else begin
          want = packed_queue.pop_front();
          if (pack_word.packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, actual %02h", want.packed_byte,
                   pack_word.packed_byte);
            error_count++;
          end
          if (pack_word.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, actual %0d", want.byte_index,
                   pack_word.byte_index);
            error_count++;
          end
          if (pack_word.final_byte !== want.final_byte) begin
            $error("final_byte: expected %0b, actual %0b", want.final_byte,
                   pack_word.final_byte);
            error_count++;
          end
          if (pack_word.bad_format !== want.bad_format) begin
            $error("bad_format: expected %0b, actual %0b", want.bad_format,
                   pack_word.bad_format);
            error_count++;
          end
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall per word, or a long hold when one is requested
  initial begin : result_sink
    int unsigned stall;
    pack_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = (sink_idle_max == 0) ? 0 : $urandom_range(0, sink_idle_max);
      end
      if (stall > 0) begin
        pack_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pack_ready <= 1'b1;
      do @(posedge clk); while (!pack_valid);
    end
  end

  // Offer one file byte after a random gap, hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    in_word_t w;
    gap = (src_idle_max == 0) ? 0 : $urandom_range(0, src_idle_max);
    w.file_byte = b;
    w.file_start = start;
    if (gap > 0) begin
      file_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    file_valid <= 1'b1;
    file_word <= w;
    do @(posedge clk); while (!file_ready);
    bytes_sent++;
  endtask

  // Stop offering, wait for every predicted word, then let the pipeline settle
  task automatic wait_drained();
    file_valid <= 1'b0;
    @(posedge clk);
    while (packed_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register access: setup cycle, access cycle, then back to idle
  task automatic apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_BLUE_THRESHOLD;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_back_threshold();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd[7:0] !== model_thresh) begin
      $error("blue_threshold: expected %0d, actual %0d", model_thresh, rd[7:0]);
      error_count++;
    end
  endtask

  task automatic write_threshold(input logic [7:0] level);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, {24'($urandom), level}, rd);
    model_thresh = level;
    read_back_threshold();
  endtask

  function automatic int unsigned image_bytes(input logic [31:0] width, height);
    if (width[31] || height[31]) return 0;
    return 24 * (width / 8) * height;
  endfunction

  // Blue values cluster around the threshold and the byte extremes
  function automatic logic [7:0] pick_blue();
    case ($urandom_range(0, 4))
      0: return model_thresh;
      1: return model_thresh + 8'd1;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send a header with the given fields, then data_bytes of pixel data
  task automatic send_image(input logic [31:0] offset, width, height, input logic [15:0] depth,
                            input int unsigned data_bytes, input logic start);
    int unsigned hdr_len;
    logic [7:0] hdr[$];
    hdr_len = (offset >= MIN_OFFSET && offset <= 255) ? offset : MIN_OFFSET;
    for (int i = 0; i < hdr_len; i++) hdr.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) begin
      hdr[POS_DATA_OFFSET + i] = offset[8*i +: 8];
      hdr[POS_WIDTH + i] = width[8*i +: 8];
      hdr[POS_HEIGHT + i] = height[8*i +: 8];
    end
    hdr[POS_DEPTH] = depth[7:0];
    hdr[POS_DEPTH + 1] = depth[15:8];
    foreach (hdr[i]) send_byte(hdr[i], start && i == 0);
    for (int i = 0; i < data_bytes; i++)
      send_byte((i % 3 == 0) ? pick_blue() : 8'($urandom), 1'b0);
  endtask

  // Random bytes as a file of their own
  task automatic send_noise(input int unsigned count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom), i == 0);
  endtask

  // Reset value of the threshold; first file parsed without a start mark
  task automatic test_reset_state();
    read_back_threshold();
    send_image(32'd54, 32'd16, 32'd1, DEPTH_24, image_bytes(16, 1), 1'b0);
    wait_drained();
  endtask

  // Threshold extremes and a middle level, then back to the reset level
  task automatic test_threshold_levels();
    logic [7:0] levels[4] = '{8'd0, 8'd255, 8'd127, THRESHOLD_RESET};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      send_image(32'd30, 32'd16, 32'd1, DEPTH_24, image_bytes(16, 1), 1'b1);
    end
  endtask

  // Each way to reject a header; the rest of the file must be dropped
  task automatic test_bad_headers();
    send_image(32'd30, 32'd16, 32'd2, 16'd16, 4, 1'b1);
    send_image(32'd30, 32'd16, 32'd2, 16'h0118, 4, 1'b1);
    send_image(32'd30, 32'(MAX_WIDTH + 1), 32'd2, DEPTH_24, 4, 1'b1);
    send_image(32'd30, 32'd16, 32'(MAX_HEIGHT + 1), DEPTH_24, 4, 1'b1);
    send_image(32'd29, 32'd16, 32'd2, DEPTH_24, 4, 1'b1);
    send_image(32'h8000_0000, 32'd16, 32'd2, DEPTH_24, 4, 1'b1);
  endtask

  // Zero or negative height, width under one byte or negative: no words
  task automatic test_empty_images();
    send_image(32'd30, 32'd16, 32'd0, DEPTH_24, 6, 1'b1);
    send_image(32'd30, 32'd16, 32'hFFFF_FFFF, DEPTH_24, 6, 1'b1);
    send_image(32'd30, 32'd7, 32'd2, DEPTH_24, 6, 1'b1);
    send_image(32'd30, 32'd0, 32'd2, DEPTH_24, 6, 1'b1);
    send_image(32'd30, 32'h8000_0000, 32'd2, DEPTH_24, 6, 1'b1);
  endtask

  // Minimum offset, odd width, maximum width and maximum height both cut short
  task automatic test_size_limits();
    send_image(32'd30, 32'd16, 32'd1, DEPTH_24, image_bytes(16, 1) + 5, 1'b1);
    send_image(32'd30, 32'd13, 32'd2, DEPTH_24, image_bytes(13, 2), 1'b1);
    src_idle_max = 0;
    sink_idle_max = 0;
    send_image(32'd30, 32'(MAX_WIDTH), 32'd1, DEPTH_24, image_bytes(8, 2), 1'b1);
    send_image(32'd30, 32'd8, 32'(MAX_HEIGHT), DEPTH_24, image_bytes(8, 2), 1'b1);
    src_idle_max = IDLE_MAX;
    sink_idle_max = IDLE_MAX;
  endtask

  // Restart inside the header, inside a pixel, and during a long skip
  task automatic test_restarts();
    send_noise(20);
    send_image(32'd54, 32'd16, 32'd2, DEPTH_24, 24 + 5, 1'b1);
    send_image(32'h7FFF_FFFF, 32'd16, 32'd2, DEPTH_24, 20, 1'b1);
    send_image(32'd40, 32'd16, 32'd1, DEPTH_24, image_bytes(16, 1), 1'b1);
  endtask

  // Hold off the result side long enough for the input to stall, then pause the sender
  task automatic test_backpressure();
    src_idle_max = 0;
    sink_hold = LONG_HOLD;
    send_image(32'd30, 32'd32, 32'd2, DEPTH_24, image_bytes(32, 2), 1'b1);
    wait_drained();
    src_idle_max = IDLE_MAX;
  endtask

  // Mostly well-formed files with random content, plus bad, empty, cut and noise files
  task automatic test_random_files();
    int unsigned byte_goal;
    int unsigned word_goal;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    byte_goal = bytes_sent + RANDOM_BYTES;
    word_goal = words_seen + RANDOM_WORDS;
    while (bytes_sent < byte_goal || words_seen < word_goal) begin
      src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      case ($urandom_range(0, 5))
        0: write_threshold(8'($urandom));
        1: wait_drained();
        default: ;
      endcase
      w = $urandom_range(8, 40);
      h = $urandom_range(1, 3);
      off = $urandom_range(30, 70);
      case ($urandom_range(0, 13))
        0: send_image(off, w, h, 16'($urandom_range(0, 23)), 30, 1'b1);
        1: send_image(off, $urandom_range(MAX_WIDTH + 1, 5000), h, DEPTH_24, 30, 1'b1);
        2: send_image(off, w, $urandom_range(MAX_HEIGHT + 1, 5000), DEPTH_24, 30, 1'b1);
        3: send_image($urandom_range(0, 29), w, h, DEPTH_24, 30, 1'b1);
        4: send_image(off, w, 32'd0, DEPTH_24, 30, 1'b1);
        5: send_image(off, w, h, DEPTH_24, $urandom_range(0, image_bytes(w, h)), 1'b1);
        6: send_noise($urandom_range(1, 40));
        default: send_image(off, w, h, DEPTH_24, image_bytes(w, h) + $urandom_range(0, 6), 1'b1);
      endcase
    end
    src_idle_max = IDLE_MAX;
    sink_idle_max = IDLE_MAX;
  endtask

  initial begin
    rst <= 1'b1;
    file_valid <= 1'b0;
    file_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_BLUE_THRESHOLD;
    pwdata <= '0;
    model_thresh = THRESHOLD_RESET;
    restart_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_threshold_levels();
    test_bad_headers();
    test_empty_images();
    test_size_limits();
    test_restarts();
    test_backpressure();
    test_random_files();

    wait_drained();
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
